>>> rtl/hpa_pkg.sv
// ----------------------------------------------------------------------------
// Hodgepodge automaton package
// Shared widths and the per-column statistics type passed out of the window
// cells.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int ValW     = 8;            // one cell state
  localparam int ColSumW  = 10;           // three cells of one column
  localparam int SumW     = 12;           // all nine cells of the window
  localparam int CntW     = 4;            // up to eight neighbors
  localparam int GainW    = 12;
  localparam int ProdW    = GainW + CntW + 1;  // two weighted counts summed
  localparam int WordW    = 2 * ValW;     // line buffer word: upper, middle

  // Statistics of one window column, seen against the current top state
  typedef struct packed {
    logic [ColSumW-1:0] sum;
    logic [1:0]         infected;
    logic [1:0]         ill;
  } col_stat_t;

endpackage

>>> rtl/hpa_col_cell.sv
// ----------------------------------------------------------------------------
// Hodgepodge window column cell
// Holds one column of the 3x3 window, takes the column of its right-hand
// neighbor on a shift and reports sum and neighbor classes of its column.
// ----------------------------------------------------------------------------
module hpa_col_cell
  import hpa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic [ValW-1:0] top_i,
  input  logic            count_mid_i,   // low for the center column
  input  logic [ValW-1:0] up_i,
  input  logic [ValW-1:0] mid_i,
  input  logic [ValW-1:0] low_i,
  output logic [ValW-1:0] up_o,
  output logic [ValW-1:0] mid_o,
  output logic [ValW-1:0] low_o,
  output col_stat_t       stat_o
);

  logic [ValW-1:0] up_q, mid_q, low_q;
  logic            inf_up, inf_mid, inf_low;
  logic            ill_up, ill_mid, ill_low;

  // Column storage, moves one place left on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q  <= '0;
      mid_q <= '0;
      low_q <= '0;
    end else if (shift_i) begin
      up_q  <= up_i;
      mid_q <= mid_i;
      low_q <= low_i;
    end
  end

  // Neighbor classes: infected strictly between 0 and top, ill at top
  assign inf_up  = (up_q  != '0) && (up_q  < top_i);
  assign inf_mid = (mid_q != '0) && (mid_q < top_i) && count_mid_i;
  assign inf_low = (low_q != '0) && (low_q < top_i);
  assign ill_up  = (up_q  == top_i);
  assign ill_mid = (mid_q == top_i) && count_mid_i;
  assign ill_low = (low_q == top_i);

  assign stat_o.sum      = ColSumW'(up_q) + ColSumW'(mid_q) + ColSumW'(low_q);
  assign stat_o.infected = 2'(inf_up) + 2'(inf_mid) + 2'(inf_low);
  assign stat_o.ill      = 2'(ill_up) + 2'(ill_mid) + 2'(ill_low);

  assign up_o  = up_q;
  assign mid_o = mid_q;
  assign low_o = low_q;

endmodule

>>> rtl/hpa_divider.sv
// ----------------------------------------------------------------------------
// Hodgepodge quotient unit
// Restoring divider, one quotient bit per cycle, for the window sum over the
// infected neighbor count.
// ----------------------------------------------------------------------------
module hpa_divider
  import hpa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [SumW-1:0] quotient_o
);

  localparam int StepW = $clog2(SumW + 1);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [SumW-1:0]  quo_q;
  logic [CntW-1:0]  rem_q, dvs_q;
  logic [CntW:0]    rem_sh, rem_sub;
  logic             fits;

  // One restoring step
  assign rem_sh  = {rem_q, quo_q[SumW-1]};
  assign fits    = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SumW-2:0], fits};
      rem_q <= fits ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/hpa_line_buf.sv
// ----------------------------------------------------------------------------
// Hodgepodge line buffer
// Two previous rows packed in one word per column, registered read, and a
// zeroing sweep over all columns after reset.
// ----------------------------------------------------------------------------
module hpa_line_buf
  import hpa_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WordW-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WordW-1:0]         wr_data_i,
  output logic                     busy_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WordW-1:0] line_mem [DEPTH];
  logic [WordW-1:0] rd_q;
  logic [AW-1:0]    clr_q;
  logic             busy_q;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      line_mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      line_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= line_mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

>>> rtl/hodgepodge_automaton_step.sv
// ----------------------------------------------------------------------------
// Hodgepodge automaton step
// One generation of a hodgepodge machine over a raster stream of cells.
// ----------------------------------------------------------------------------
// Cells enter one per transfer in raster order and the next states leave
// about one row and one column behind, border cells as 0, with the final
// cell of a generation marked by last_of_frame. The block works on one cell
// at a time: a cell that yields no result is only loaded into the window; a
// cell that does also passes the count state, the 12-step bit-serial divide
// (its quotient serves infected cells), the final state and one emit step
// per result (one to four). The result register frees the input side once
// the last result of a cell is loaded. After reset a zeroing sweep clears all
// MAX_COLS line buffer columns, during which no cell is taken; register
// writes are taken at any time and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module hodgepodge_automaton_step
  import hpa_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cell input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cell_value_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_row_o,
  output logic [7:0]  out_col_o,
  output logic [7:0]  new_value_o,
  output logic        last_of_frame_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CCW = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
  localparam int RCW = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
  localparam int CXW = (CW > 8) ? CW : 8;
  localparam int RXW = (RW > 8) ? RW : 8;
  localparam int QW  = SumW + 2;

  // register indexes
  localparam logic [2:0] CFG_STATE_COUNT = 3'd0;
  localparam logic [2:0] CFG_INFECT_GAIN = 3'd1;
  localparam logic [2:0] CFG_ILL_GAIN    = 3'd2;
  localparam logic [2:0] CFG_SPEED_BIAS  = 3'd3;
  localparam logic [2:0] CFG_GRID_ROWS   = 3'd4;
  localparam logic [2:0] CFG_GRID_COLS   = 3'd5;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // center cell classes
  localparam logic [1:0] CLS_HEALTHY  = 2'd0;
  localparam logic [1:0] CLS_INFECTED = 2'd1;
  localparam logic [1:0] CLS_ILL      = 2'd2;
  localparam logic [1:0] CLS_OVER     = 2'd3;

  // result slots of one cell, in output order
  localparam logic [1:0] SLOT_CENTRE = 2'd0;
  localparam logic [1:0] SLOT_RIGHT  = 2'd1;
  localparam logic [1:0] SLOT_BELOW  = 2'd2;
  localparam logic [1:0] SLOT_CORNER = 2'd3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [8:0]        state_count_q, grid_rows_q, grid_cols_q;
  logic [GainW-1:0]  infect_gain_q, ill_gain_q;
  logic signed [7:0] speed_bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= 9'd13;
      infect_gain_q <= 12'd792;
      ill_gain_q    <= 12'd256;
      speed_bias_q  <= 8'sd0;
      grid_rows_q   <= 9'd20;
      grid_cols_q   <= 9'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STATE_COUNT: state_count_q <= cfg_data_i[8:0];
        CFG_INFECT_GAIN: infect_gain_q <= cfg_data_i;
        CFG_ILL_GAIN:    ill_gain_q    <= cfg_data_i;
        CFG_SPEED_BIAS:  speed_bias_q  <= $signed(cfg_data_i[7:0]);
        CFG_GRID_ROWS:   grid_rows_q   <= cfg_data_i[8:0];
        CFG_GRID_COLS:   grid_cols_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and top state
  logic [CCW-1:0]  cols_ext, cols_eff;
  logic [RCW-1:0]  rows_ext, rows_eff;
  logic [8:0]      sc_m1;
  logic [ValW-1:0] top_val;

  always_comb begin
    cols_ext = CCW'(grid_cols_q);
    rows_ext = RCW'(grid_rows_q);
    if (cols_ext < CCW'(3)) begin
      cols_eff = CCW'(3);
    end else if (cols_ext > CCW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_ext < RCW'(3)) begin
      rows_eff = RCW'(3);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    sc_m1 = state_count_q - 9'd1;
    if (state_count_q < 9'd2) begin
      top_val = 8'd1;
    end else if (state_count_q > 9'd256) begin
      top_val = 8'd255;
    end else begin
      top_val = sc_m1[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Raster position
  // --------------------------------------------------------------------------
  logic [CW-1:0]  col_q, c_now, col_nx;
  logic [RW-1:0]  row_q, r_now, row_nx;
  logic [RCW-1:0] row_inc;
  logic           col_wrap, last_col, last_row;

  always_comb begin
    col_wrap = (CCW'(col_q) >= cols_eff);
    c_now    = col_wrap ? '0 : col_q;
    row_inc  = col_wrap ? RCW'(row_q) + RCW'(1) : RCW'(row_q);
    r_now    = (row_inc >= rows_eff) ? '0 : row_inc[RW-1:0];
    last_col = (CCW'(c_now) == cols_eff - CCW'(1));
    last_row = (RCW'(r_now) == rows_eff - RCW'(1));
    if (last_col) begin
      col_nx = '0;
      row_nx = last_row ? '0 : r_now + RW'(1);
    end else begin
      col_nx = c_now + CW'(1);
      row_nx = r_now;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [2:0] state_q, state_d;
  logic       in_accept, out_load_ok, clr_busy, div_done;
  logic [1:0] slot_q, slot_nx;
  logic       slot_last;
  logic       emit_q, inner_q, lc_q, lr_q;
  logic       out_valid_q;

  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (!clr_busy) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_LOAD;
      S_LOAD:  state_d = emit_q ? S_COUNT : S_IDLE;
      S_COUNT: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_FINAL;
      S_FINAL: state_d = S_EMIT;
      S_EMIT:  if (out_load_ok && slot_last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Next present result slot of the current cell
  always_comb begin
    slot_nx   = slot_q;
    slot_last = 1'b1;
    case (slot_q)
      SLOT_CENTRE: begin
        if (lc_q) begin
          slot_nx   = SLOT_RIGHT;
          slot_last = 1'b0;
        end else if (lr_q) begin
          slot_nx   = SLOT_BELOW;
          slot_last = 1'b0;
        end
      end
      SLOT_RIGHT: begin
        if (lr_q) begin
          slot_nx   = SLOT_BELOW;
          slot_last = 1'b0;
        end
      end
      SLOT_BELOW: begin
        if (lc_q) begin
          slot_nx   = SLOT_CORNER;
          slot_last = 1'b0;
        end
      end
      SLOT_CORNER: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= SLOT_CENTRE;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        col_q  <= col_nx;
        row_q  <= row_nx;
        slot_q <= SLOT_CENTRE;
      end else if (state_q == S_EMIT && out_load_ok) begin
        slot_q <= slot_nx;
      end
    end
  end

  // Per-cell payload captured on the input transfer
  logic [CW-1:0]   c_q;
  logic [RW-1:0]   r_q;
  logic [ValW-1:0] v_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      v_q     <= cell_value_i;
      c_q     <= c_now;
      r_q     <= r_now;
      lc_q    <= last_col;
      lr_q    <= last_row;
      emit_q  <= (r_now != '0) && (c_now != '0);
      inner_q <= (r_now >= RW'(2)) && (c_now >= CW'(2));
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: word holds {row r-2, row r-1} of one column
  // --------------------------------------------------------------------------
  logic [WordW-1:0] rd_word;

  hpa_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (c_now),
    .rd_data_o (rd_word),
    .wr_en_i   (state_q == S_LOAD),
    .wr_addr_i (c_q),
    .wr_data_i ({rd_word[ValW-1:0], v_q}),
    .busy_o    (clr_busy)
  );

  // --------------------------------------------------------------------------
  // Window: chain of three column cells, new column enters on the right
  // --------------------------------------------------------------------------
  logic [ValW-1:0] win_up  [4];
  logic [ValW-1:0] win_mid [4];
  logic [ValW-1:0] win_low [4];
  col_stat_t       col_stat [3];

  assign win_up[3]  = rd_word[WordW-1:ValW];
  assign win_mid[3] = rd_word[ValW-1:0];
  assign win_low[3] = v_q;

  for (genvar j = 0; j < 3; j++) begin : g_col
    hpa_col_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (state_q == S_LOAD),
      .top_i       (top_val),
      .count_mid_i (j != 1),
      .up_i        (win_up[j+1]),
      .mid_i       (win_mid[j+1]),
      .low_i       (win_low[j+1]),
      .up_o        (win_up[j]),
      .mid_o       (win_mid[j]),
      .low_o       (win_low[j]),
      .stat_o      (col_stat[j])
    );
  end

  // --------------------------------------------------------------------------
  // Next-state arithmetic
  // --------------------------------------------------------------------------
  logic [SumW-1:0]  sum9, quotient;
  logic [CntW-1:0]  inf9, ill9, inf_q, ill_q;
  logic [1:0]       cls_d, cls_q;
  logic [ProdW-1:0] heal_sum;
  logic [8:0]       heal_q;
  logic signed [QW-1:0] q_biased;
  logic [ValW-1:0]  nv_d, nv_q;

  assign sum9 = SumW'(col_stat[0].sum) + SumW'(col_stat[1].sum) + SumW'(col_stat[2].sum);
  assign inf9 = CntW'(col_stat[0].infected) + CntW'(col_stat[1].infected)
              + CntW'(col_stat[2].infected);
  assign ill9 = CntW'(col_stat[0].ill) + CntW'(col_stat[1].ill) + CntW'(col_stat[2].ill);

  always_comb begin
    if (win_mid[1] == '0) begin
      cls_d = CLS_HEALTHY;
    end else if (win_mid[1] < top_val) begin
      cls_d = CLS_INFECTED;
    end else if (win_mid[1] == top_val) begin
      cls_d = CLS_ILL;
    end else begin
      cls_d = CLS_OVER;
    end
  end

  hpa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_COUNT),
    .dividend_i (sum9 - SumW'(1)),
    .divisor_i  (inf9),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Weighted neighbor counts for a healthy center
  assign heal_sum = ProdW'(inf_q) * ProdW'(infect_gain_q)
                  + ProdW'(ill_q) * ProdW'(ill_gain_q);

  assign q_biased = $signed({2'b00, quotient})
                  + $signed({{(QW - 8){speed_bias_q[7]}}, speed_bias_q});

  always_comb begin
    case (cls_q)
      CLS_HEALTHY:  nv_d = (heal_q > {1'b0, top_val}) ? top_val : heal_q[7:0];
      CLS_INFECTED: begin
        if (inf_q == '0) begin
          nv_d = top_val;
        end else if (q_biased < $signed(QW'(0))) begin
          nv_d = '0;
        end else if (q_biased > $signed(QW'(top_val))) begin
          nv_d = top_val;
        end else begin
          nv_d = q_biased[7:0];
        end
      end
      CLS_ILL:  nv_d = '0;
      CLS_OVER: nv_d = top_val;
      default:  nv_d = '0;
    endcase
    if (!inner_q) begin
      nv_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COUNT) begin
      inf_q <= inf9;
      ill_q <= ill9;
      cls_q <= cls_d;
    end
    if (state_q == S_DIV) begin
      heal_q <= heal_sum[ProdW-1:8];
    end
    if (state_q == S_FINAL) begin
      nv_q <= nv_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [RXW-1:0] r_x, r_m1;
  logic [CXW-1:0] c_x, c_m1;
  logic           row_sel, col_sel;
  logic [7:0]     out_row_q, out_col_q, new_value_q;
  logic           last_q;

  assign r_x     = RXW'(r_q);
  assign c_x     = CXW'(c_q);
  assign r_m1    = r_x - RXW'(1);
  assign c_m1    = c_x - CXW'(1);
  assign row_sel = (slot_q == SLOT_BELOW) || (slot_q == SLOT_CORNER);
  assign col_sel = (slot_q == SLOT_RIGHT) || (slot_q == SLOT_CORNER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_load_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_load_ok) begin
      out_row_q   <= row_sel ? r_x[7:0] : r_m1[7:0];
      out_col_q   <= col_sel ? c_x[7:0] : c_m1[7:0];
      new_value_q <= (slot_q == SLOT_CENTRE) ? nv_q : 8'd0;
      last_q      <= (slot_q == SLOT_CORNER);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign new_value_o     = new_value_q;
  assign last_of_frame_o = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_LOAD))
    else $error("input transfer not followed by window load");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_frame_o) |-> (new_value_o == 8'd0))
    else $error("final cell of a generation is not a zero border cell");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("cell taken during line buffer clearing");

endmodule

>>> test/hpa_test_pkg.sv
// ----------------------------------------------------------------------------
// Hodgepodge automaton verification package
// Register indexes of the configuration write channel, shared by the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package hpa_test_pkg;

  typedef enum logic [2:0] {
    RegStateCount = 3'd0,
    RegInfectGain = 3'd1,
    RegIllGain    = 3'd2,
    RegSpeedBias  = 3'd3,
    RegGridRows   = 3'd4,
    RegGridCols   = 3'd5
  } cfg_reg_e;

endpackage

>>> test/hodgepodge_automaton_step_checker.sv
// ----------------------------------------------------------------------------
// Hodgepodge automaton step checker
// Watches the cell, result and register channels, keeps its own copy of the
// line stores, window and settings, and compares every result transfer
// with the oldest predicted cell state.
// ----------------------------------------------------------------------------
module hodgepodge_automaton_step_checker
  import hpa_pkg::*;
  import hpa_test_pkg::*;
#(
  parameter int MaxCols = 256,
  parameter int MaxRows = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ValW-1:0]  cell_value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ValW-1:0]  out_row_i,
  input  logic [ValW-1:0]  out_col_i,
  input  logic [ValW-1:0]  new_value_i,
  input  logic             last_of_frame_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [ValW-1:0] row;
    logic [ValW-1:0] col;
    logic [ValW-1:0] value;
    logic            last;
  } cell_result_t;

  // predicted next states, oldest first
  cell_result_t next_cells_q[$];

  // settings as last written
  logic [8:0]  num_states;
  logic [11:0] infect_weight;
  logic [11:0] ill_weight;
  int          speed_bias_r;
  logic [8:0]  grid_rows_r;
  logic [8:0]  grid_cols_r;

  // line stores (rows r-2 and r-1), 3x3 window, next input position
  logic [ValW-1:0] row_above2 [MaxCols];
  logic [ValW-1:0] row_above1 [MaxCols];
  logic [ValW-1:0] window [9];
  int unsigned     row_at;
  int unsigned     col_at;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                           int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_result(int unsigned r, int unsigned c,
                                      logic [ValW-1:0] v, logic last);
    next_cells_q.push_back('{row: ValW'(r), col: ValW'(c), value: v, last: last});
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : model
    cell_result_t want;
    int unsigned  rows, cols, top, r, c, i;
    int unsigned  infected, ill, total, v, centre;
    int           q;
    logic         last_col, last_row;
    logic [ValW-1:0] nv;

    if (!rst_ni) begin
      next_cells_q.delete();
      fail_count_o = 0;
      num_states    = 9'd13;
      infect_weight = 12'd792;
      ill_weight    = 12'd256;
      speed_bias_r  = 0;
      grid_rows_r   = 9'd20;
      grid_cols_r   = 9'd20;
      for (i = 0; i < MaxCols; i++) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      for (i = 0; i < 9; i++) window[i] = '0;
      row_at = 0;
      col_at = 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (next_cells_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d value %0d last %0d",
                                    out_row_i, out_col_i, new_value_i, last_of_frame_i));
        end else begin
          want = next_cells_q.pop_front();
          if (out_row_i !== want.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", out_row_i, want.row));
          if (out_col_i !== want.col)
            report_mismatch($sformatf("out_col %0d, expected %0d (row %0d)",
                                      out_col_i, want.col, want.row));
          if (new_value_i !== want.value)
            report_mismatch($sformatf("new_value %0d, expected %0d at row %0d col %0d",
                                      new_value_i, want.value, want.row, want.col));
          if (last_of_frame_i !== want.last)
            report_mismatch($sformatf("last_of_frame %0d, expected %0d at row %0d col %0d",
                                      last_of_frame_i, want.last, want.row, want.col));
        end
      end

      // cell transfer: advance the window and predict what it releases
      if (in_valid_i && !in_stall_i) begin
        rows = clamp_to(grid_rows_r, 3, MaxRows);
        cols = clamp_to(grid_cols_r, 3, MaxCols);
        top  = clamp_to(num_states, 2, 256) - 1;

        // a shrunk size wraps the position
        if (col_at >= cols) begin
          col_at = 0;
          row_at++;
        end
        if (row_at >= rows) row_at = 0;
        r = row_at;
        c = col_at;

        for (i = 0; i < 3; i++) begin
          window[3*i]   = window[3*i+1];
          window[3*i+1] = window[3*i+2];
        end
        window[2] = row_above2[c];
        window[5] = row_above1[c];
        window[8] = cell_value_i;
        row_above2[c] = row_above1[c];
        row_above1[c] = cell_value_i;

        last_col = (c == cols - 1);
        last_row = (r == rows - 1);

        if (r >= 1 && c >= 1) begin
          nv = '0;
          if (r >= 2 && c >= 2) begin
            // classify the eight neighbors; above-top cells only add to the sum
            infected = 0;
            ill      = 0;
            total    = 0;
            for (i = 0; i < 9; i++) begin
              v = window[i];
              total += v;
              if (i != 4) begin
                if (v > 0 && v < top) infected++;
                else if (v == top) ill++;
              end
            end
            centre = window[4];
            if (centre == 0) begin
              v  = (infected * infect_weight + ill * ill_weight) >> 8;
              nv = ValW'((v > top) ? top : v);
            end else if (centre < top) begin
              if (infected == 0) begin
                nv = ValW'(top);
              end else begin
                q = int'((total - 1) / infected) + speed_bias_r;
                if (q < 0) nv = '0;
                else if (q > int'(top)) nv = ValW'(top);
                else nv = ValW'(q);
              end
            end else if (centre == top) begin
              nv = '0;
            end else begin
              nv = ValW'(top);
            end
          end
          push_result(r - 1, c - 1, nv, 1'b0);
          if (last_col) push_result(r - 1, c, '0, 1'b0);
          if (last_row) begin
            push_result(r, c - 1, '0, 1'b0);
            if (last_col) push_result(r, c, '0, 1'b1);
          end
        end

        if (last_col) begin
          col_at = 0;
          row_at = last_row ? 0 : r + 1;
        end else begin
          col_at = c + 1;
        end
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegStateCount: num_states    = cfg_data_i[8:0];
          RegInfectGain: infect_weight = cfg_data_i;
          RegIllGain:    ill_weight    = cfg_data_i;
          RegSpeedBias:  speed_bias_r  = int'($signed(cfg_data_i[7:0]));
          RegGridRows:   grid_rows_r   = cfg_data_i[8:0];
          RegGridCols:   grid_cols_r   = cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
    pending_o = next_cells_q.size();
  end

endmodule

>>> test/hodgepodge_automaton_step_test.sv
// ----------------------------------------------------------------------------
// Hodgepodge automaton step testbench
// Streams a hand-made 5x5 generation and then random cells over a series of
// grid sizes and rule settings, with random idling on both channels and one
// long result hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module hodgepodge_automaton_step_test
  import hpa_test_pkg::*;
();

  localparam int MaxCols     = 256;
  localparam int MaxRows     = 256;
  localparam int SettlePause = 40;    // covers a cell that yields no result
  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 2000;  // zeroing sweep, hold-off and stalls fit

  typedef struct packed {
    int states;
    int infect;
    int ill;
    int bias;
    int rows;
    int cols;
    int cells;
  } phase_t;

  // settings per random phase; out-of-range values check the clamping
  phase_t plan [10] = '{
    '{13,  792,  256,    0,  20,  20, 60},   // reset values
    '{2,   4095, 4095, 127,   3,   3, 27},
    '{256, 0,    0,   -128,   4,   7, 40},
    '{0,   100,  3000,  -5,   0,   2, 18},
    '{511, 1234, 77,    60,   6,   5, 45},
    '{20,  500,  900,    2,   5, 511, 30},   // widest grid, first row only
    '{6,   2048, 1024,  -2,   5,   4, 48},   // narrower: position wraps
    '{1,   4095, 0,     -1,   7,   6, 50},
    '{10,  300,  600,    3,   8,   8, 64},
    '{3,   792,  256,    0,   4,   4, 25}
  };

  // one 5x5 generation: healthy, infected, ill and above-top centers
  logic [7:0] first_frame [25] = '{
    8'd0,   8'd255, 8'd12, 8'd1,   8'd0,
    8'd12,  8'd0,   8'd5,  8'd12,  8'd7,
    8'd3,   8'd12,  8'd11, 8'd200, 8'd0,
    8'd1,   8'd6,   8'd0,  8'd12,  8'd4,
    8'd255, 8'd0,   8'd9,  8'd2,   8'd12
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  cell_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic [7:0]  new_value;
  logic        last_of_frame;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  hodgepodge_automaton_step #(
    .MAX_COLS(MaxCols),
    .MAX_ROWS(MaxRows)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cell_value_i   (cell_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .new_value_o    (new_value),
    .last_of_frame_o(last_of_frame),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  hodgepodge_automaton_step_checker #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cell_value_i   (cell_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_row_i      (out_row),
    .out_col_i      (out_col),
    .new_value_i    (new_value),
    .last_of_frame_i(last_of_frame),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side: random stall, plus one long hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
    end
  end

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one cell after a random gap; returns at the edge of its transfer
  task automatic send_cell(logic [7:0] v);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [11:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(phase_t p);
    write_reg(RegStateCount, 12'(p.states));
    write_reg(RegInfectGain, 12'(p.infect));
    write_reg(RegIllGain,    12'(p.ill));
    write_reg(RegSpeedBias,  12'(p.bias));
    write_reg(RegGridRows,   12'(p.rows));
    write_reg(RegGridCols,   12'(p.cols));
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted result has left, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettlePause) @(posedge clk);
  endtask

  // mostly legal states, some zeros and tops, a few arbitrary bytes
  function automatic logic [7:0] random_cell(int unsigned top);
    case ($urandom_range(19))
      0:       return 8'($urandom_range(255));
      1, 2:    return 8'd0;
      3:       return 8'(top);
      default: return 8'($urandom_range(top));
    endcase
  endfunction

  initial begin
    int          k;
    int          n;
    int unsigned top;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 63;
    write_settings('{13, 792, 256, 0, 5, 5, 25});
    foreach (first_frame[i]) send_cell(first_frame[i]);

    for (k = 0; k < 10; k++) begin
      if (k == 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 33;
      end
      if (k == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      write_settings(plan[k]);
      // long result hold-off while cells keep coming
      if (k == 7) hold_go <= 1'b1;
      if (plan[k].states < 2) top = 1;
      else if (plan[k].states > 256) top = 255;
      else top = plan[k].states - 1;
      for (n = 0; n < plan[k].cells; n++) send_cell(random_cell(top));
    end

    settle();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
